[sv/audio_phase_locked_loop_macros.svh]
`ifndef AUDIO_PHASE_LOCKED_LOOP_MACROS_SVH
`define AUDIO_PHASE_LOCKED_LOOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define APLL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define APLL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/apll_pkg.sv]
`default_nettype none

package apll_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int PHASE_W    = 24;
    localparam int COS_DEPTH  = 1024;
    localparam int COS_IDX_W  = $clog2(COS_DEPTH);
    localparam int LVL_W      = 24;
    localparam int STEP_W     = 24;
    localparam int GAIN_W     = 23;
    localparam int COEFF_W    = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // loop gain product and the split of m into high and low parts
    localparam int GPROD_W = LVL_W + GAIN_W;
    localparam int LO_W    = 31;
    localparam int HI_W    = GPROD_W - LO_W;
    localparam int HPROD_W = STEP_W + HI_W;
    localparam int INC_W   = HPROD_W + 1;

    localparam logic [STEP_W-1:0]  STEP_RST  = 24'd349525;
    localparam logic [GAIN_W-1:0]  GAIN_RST  = '0;
    localparam logic [COEFF_W-1:0] COEFF_RST = 16'd9;
    localparam logic               MODE_RST  = 1'b0;
    localparam logic signed [GAIN_W-1:0] GAIN_MAX = 23'sd2560000;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_GAIN     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COEFF  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DETECTOR_MODE = 8'd3;

    localparam logic DET_MULT = 1'b0;
    localparam logic DET_XOR  = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef t_sample t_cos_rom [COS_DEPTH];

    typedef struct packed {
        logic [STEP_W-1:0]  phase_step;
        logic [GAIN_W-1:0]  loop_gain;
        logic [COEFF_W-1:0] filter_coeff;
        logic               detector_mode;
    } t_cfg;

    typedef enum logic [2:0] {
        MUL_DET,
        MUL_FLT,
        MUL_GAIN,
        MUL_HI,
        MUL_LO
    } t_mul_sel;

    typedef struct packed {
        logic     load_ref;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     upd_level;
        logic     ld_lo;
        logic     ld_acc;
        logic     upd_phase;
        logic     rom_rd;
        logic     ld_out;
    } t_dp_cmd;

    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    // cosine over one cycle, quarter-wave taylor series in q30
    function automatic t_cos_rom build_cos_rom();
        t_cos_rom rom;
        longint   f, q, r, x, x2, c, s, v, lim;
        lim = (longint'(1) << (SAMPLE_W - 1)) - 1;
        for (int i = 0; i < COS_DEPTH; i++) begin
            f  = (longint'(i) << 30) / COS_DEPTH;
            q  = (f >>> 28) & 3;
            r  = f & ((longint'(1) << 28) - 1);
            x  = (r * HALF_PI_Q30) >>> 28;
            x2 = (x * x) >>> 30;
            c  = Q30_ONE;
            s  = Q30_ONE;
            c  = Q30_ONE - ((x2 * c) / Q30_ONE) / 132;
            s  = Q30_ONE - ((x2 * s) / Q30_ONE) / 156;
            c  = Q30_ONE - ((x2 * c) / Q30_ONE) / 90;
            s  = Q30_ONE - ((x2 * s) / Q30_ONE) / 110;
            c  = Q30_ONE - ((x2 * c) / Q30_ONE) / 56;
            s  = Q30_ONE - ((x2 * s) / Q30_ONE) / 72;
            c  = Q30_ONE - ((x2 * c) / Q30_ONE) / 30;
            s  = Q30_ONE - ((x2 * s) / Q30_ONE) / 42;
            c  = Q30_ONE - ((x2 * c) / Q30_ONE) / 12;
            s  = Q30_ONE - ((x2 * s) / Q30_ONE) / 20;
            c  = Q30_ONE - ((x2 * c) / Q30_ONE) / 2;
            s  = Q30_ONE - ((x2 * s) / Q30_ONE) / 6;
            s  = (x * s) / Q30_ONE;
            if (q == 0) begin
                v = c;
            end else if (q == 1) begin
                v = -s;
            end else if (q == 2) begin
                v = -c;
            end else begin
                v = s;
            end
            v = (v * (longint'(1) << (SAMPLE_W - 1)) + (longint'(1) << 29)) >>> 30;
            if (v > lim) begin
                v = lim;
            end
            if (v < -lim) begin
                v = -lim;
            end
            rom[i] = SAMPLE_W'(v);
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

[sv/audio_phase_locked_loop.sv]
// audio phase-locked loop with multiplier or one-bit xor phase detector
// input channel: one reference sample (q1.15) per beat on i_in_valid/o_in_ready
// output channel: oscillator cosine (q1.15) and its 24-bit phase per beat on
//   o_out_valid/i_out_ready, exactly one result beat for each input beat
// config channel: i_cfg_valid/o_cfg_ready with register index and data;
//   0 phase_step, 1 loop_gain, 2 filter_coeff, 3 detector_mode; other indexes
//   are ignored; o_cfg_ready is always high; write only while the block is idle
// latency: the result beat appears 9 cycles after the input beat is taken
// throughput: one item every 10 cycles; one shared 25x32 multiplier forms the
//   detector, lowpass and loop gain products and the two halves of the phase
//   increment in turn, then a registered cosine rom read finishes the item
// o_in_ready is high only between items; a result waiting for the receiver
//   does not block the next beat from being taken and worked on, but the new
//   result is held back until the pending one has gone
// reset (synchronous, active low) clears phase, lowpass level and the stored
//   oscillator sample, loads the register defaults and drops o_out_valid
`default_nettype none

module audio_phase_locked_loop (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [apll_pkg::SAMPLE_W-1:0]    i_ref_sample,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [apll_pkg::SAMPLE_W-1:0]         o_osc_sample,
    output logic [apll_pkg::PHASE_W-1:0]          o_phase_word,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [apll_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [apll_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import apll_pkg::*;

    t_cfg    cfg;
    t_dp_cmd cmd;

    apll_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    apll_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    apll_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg        (cfg),
        .i_ref_sample (i_ref_sample),
        .o_osc_sample (o_osc_sample),
        .o_phase_word (o_phase_word)
    );

endmodule

`default_nettype wire

[sv/apll_cfg.sv]
`default_nettype none

module apll_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [apll_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [apll_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output apll_pkg::t_cfg                        o_cfg
);
    import apll_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic signed [GAIN_W-1:0] gain_wr;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;
    assign gain_wr     = $signed(i_cfg_data[GAIN_W-1:0]);

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PHASE_STEP: begin
                    n_cfg.phase_step = i_cfg_data[STEP_W-1:0];
                end
                CFG_LOOP_GAIN: begin
                    // only the positive side is limited
                    n_cfg.loop_gain = (gain_wr > GAIN_MAX) ? GAIN_MAX : gain_wr;
                end
                CFG_FILTER_COEFF: begin
                    n_cfg.filter_coeff = i_cfg_data[COEFF_W-1:0];
                end
                CFG_DETECTOR_MODE: begin
                    n_cfg.detector_mode = i_cfg_data[0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step    <= STEP_RST;
            r_cfg.loop_gain     <= GAIN_RST;
            r_cfg.filter_coeff  <= COEFF_RST;
            r_cfg.detector_mode <= MODE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

[sv/apll_ctrl.sv]
`default_nettype none

`include "audio_phase_locked_loop_macros.svh"

module apll_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output apll_pkg::t_dp_cmd o_cmd
);
    import apll_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DET,
        S_FLT,
        S_LVL,
        S_GAIN,
        S_HI,
        S_LO,
        S_PH,
        S_ROM,
        S_OUT
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    t_dp_cmd cmd;

    assign o_cmd       = cmd;
    assign o_out_valid = r_out_valid;

    always_comb begin
        cmd         = '0;
        n_state     = r_state;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid & ~i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.load_ref = 1'b1;
                    n_state      = S_DET;
                end
            end
            S_DET: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DET;
                n_state     = S_FLT;
            end
            S_FLT: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_FLT;
                n_state     = S_LVL;
            end
            S_LVL: begin
                cmd.upd_level = 1'b1;
                n_state       = S_GAIN;
            end
            S_GAIN: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GAIN;
                n_state     = S_HI;
            end
            S_HI: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_HI;
                cmd.ld_lo   = 1'b1;
                n_state     = S_LO;
            end
            S_LO: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LO;
                cmd.ld_acc  = 1'b1;
                n_state     = S_PH;
            end
            S_PH: begin
                cmd.upd_phase = 1'b1;
                n_state       = S_ROM;
            end
            S_ROM: begin
                cmd.rom_rd = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                // hold here while the previous result beat is still pending
                if (!r_out_valid || i_out_ready) begin
                    cmd.ld_out  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `APLL_ASSERT_IMP(a_load_out_free, i_clk, i_rst_n, cmd.ld_out, !r_out_valid || i_out_ready, "output overwritten while pending")
    `APLL_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_DET, "accepted beat did not start work")
    `APLL_ASSERT_NXT(a_out_after_load, i_clk, i_rst_n, cmd.ld_out, r_out_valid && r_state == S_IDLE, "loaded result not presented")
    `APLL_ASSERT_IMP(a_cmd_exclusive, i_clk, i_rst_n, 1'b1, $onehot0({cmd.load_ref, cmd.upd_level, cmd.upd_phase, cmd.rom_rd, cmd.ld_out}), "conflicting datapath commands")

endmodule

`default_nettype wire

[sv/apll_dp.sv]
`default_nettype none

module apll_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire apll_pkg::t_dp_cmd              i_cmd,
    input  wire apll_pkg::t_cfg                 i_cfg,
    input  wire logic [apll_pkg::SAMPLE_W-1:0]  i_ref_sample,
    output logic [apll_pkg::SAMPLE_W-1:0]       o_osc_sample,
    output logic [apll_pkg::PHASE_W-1:0]        o_phase_word
);
    import apll_pkg::*;

    localparam t_cos_rom COS_ROM = build_cos_rom();
    localparam logic signed [LVL_W-1:0] LVL_MAX = {1'b0, {(LVL_W-1){1'b1}}};
    localparam logic signed [LVL_W-1:0] LVL_MIN = {1'b1, {(LVL_W-1){1'b0}}};
    localparam logic signed [INC_W-1:0] INC_POS = INC_W'(64'sd8388608);
    localparam logic signed [INC_W-1:0] INC_NEG = -INC_W'(64'sd8388608);
    localparam logic signed [GPROD_W-1:0] M_ONE = GPROD_W'(64'sd2147483648);

    logic signed [SAMPLE_W-1:0] r_ref;
    logic signed [PROD_W-1:0]   r_prod;
    logic [LO_W-1:0]            r_lo;
    logic signed [HPROD_W-1:0]  r_acc;
    logic signed [LVL_W-1:0]    r_level;
    logic [PHASE_W-1:0]         r_phase;
    logic signed [SAMPLE_W-1:0] r_prev;
    logic [SAMPLE_W-1:0]        r_osc_out;
    logic [PHASE_W-1:0]         r_phase_word;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [LVL_W:0]      det_shift;
    logic signed [LVL_W-1:0]    det_mul;
    logic signed [LVL_W-1:0]    det_xor;
    logic signed [LVL_W-1:0]    det;
    logic signed [LVL_W:0]      diff;
    logic                       ref_pos;
    logic                       prev_pos;
    logic signed [GPROD_W-1:0]  m_val;
    logic signed [HI_W-1:0]     m_hi;
    logic signed [INC_W-1:0]    inc_full;
    logic signed [LVL_W:0]      inc;

    // product of two q1.15 samples, floor-rescaled to q1.23
    assign det_shift = r_prod[2*SAMPLE_W-1 -: LVL_W+1];
    always_comb begin
        if (det_shift > (LVL_W+1)'(LVL_MAX)) begin
            det_mul = LVL_MAX;
        end else if (det_shift < (LVL_W+1)'(LVL_MIN)) begin
            det_mul = LVL_MIN;
        end else begin
            det_mul = det_shift[LVL_W-1:0];
        end
    end

    assign ref_pos  = !r_ref[SAMPLE_W-1] && (r_ref != '0);
    assign prev_pos = !r_prev[SAMPLE_W-1] && (r_prev != '0);
    assign det_xor  = (ref_pos != prev_pos) ? LVL_MAX : LVL_MIN;
    assign det      = (i_cfg.detector_mode == DET_XOR) ? det_xor : det_mul;
    assign diff     = (LVL_W+1)'(det) - (LVL_W+1)'(r_level);

    // m = 1.0 in q.31 plus level times gain, split at bit 31
    assign m_val = r_prod[GPROD_W-1:0] + M_ONE;
    assign m_hi  = m_val[GPROD_W-1 -: HI_W];

    // low half product is signed, so it is sign-extended before the add
    assign inc_full = INC_W'(r_acc) + INC_W'($signed(r_prod[PROD_W-1:LO_W]));
    always_comb begin
        if (inc_full > INC_POS) begin
            inc = INC_POS[LVL_W:0];
        end else if (inc_full < INC_NEG) begin
            inc = INC_NEG[LVL_W:0];
        end else begin
            inc = inc_full[LVL_W:0];
        end
    end

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_DET: begin
                mul_a = MUL_A_W'(r_ref);
                mul_b = MUL_B_W'(r_prev);
            end
            MUL_FLT: begin
                mul_a = MUL_A_W'(diff);
                mul_b = MUL_B_W'({1'b0, i_cfg.filter_coeff});
            end
            MUL_GAIN: begin
                mul_a = MUL_A_W'(r_level);
                mul_b = MUL_B_W'($signed(i_cfg.loop_gain));
            end
            MUL_HI: begin
                mul_a = MUL_A_W'($signed(i_cfg.phase_step));
                mul_b = MUL_B_W'(m_hi);
            end
            MUL_LO: begin
                mul_a = MUL_A_W'($signed(i_cfg.phase_step));
                mul_b = MUL_B_W'({1'b0, r_lo});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_ref) begin
            r_ref <= i_ref_sample;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.ld_lo) begin
            r_lo <= m_val[LO_W-1:0];
        end
        if (i_cmd.ld_acc) begin
            r_acc <= r_prod[HPROD_W-1:0];
        end
        if (i_cmd.ld_out) begin
            r_osc_out    <= r_prev;
            r_phase_word <= r_phase;
        end
    end

    // loop state; r_prev is also the registered cosine rom output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_phase <= '0;
            r_prev  <= '0;
        end else begin
            if (i_cmd.upd_level) begin
                r_level <= r_level + r_prod[LVL_W+COEFF_W-1:COEFF_W];
            end
            if (i_cmd.upd_phase) begin
                r_phase <= r_phase + inc[PHASE_W-1:0];
            end
            if (i_cmd.rom_rd) begin
                r_prev <= COS_ROM[r_phase[PHASE_W-1 -: COS_IDX_W]];
            end
        end
    end

    assign o_osc_sample = r_osc_out;
    assign o_phase_word = r_phase_word;

endmodule

`default_nettype wire

[verif/apll_loop_checker.sv]
module apll_loop_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [apll_pkg::SAMPLE_W-1:0]   i_ref_sample,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [apll_pkg::SAMPLE_W-1:0]   i_osc_sample,
    input  logic [apll_pkg::PHASE_W-1:0]    i_phase_word,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [apll_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [apll_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fails,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import apll_pkg::*;

    localparam longint Q30_UNIT     = 64'sd1073741824;
    localparam longint QTR_TURN_Q30 = 64'sd1686629713;
    localparam longint LEVEL_TOP    = (longint'(1) << (LVL_W - 1)) - 1;
    localparam longint LEVEL_BOTTOM = -(longint'(1) << (LVL_W - 1));
    localparam longint HALF_TURN    = longint'(1) << (PHASE_W - 1);
    // q2.30 product of two samples brought down to the q1.23 level
    localparam int     DET_SHIFT    = 2 * (SAMPLE_W - 1) - (LVL_W - 1);

    typedef struct packed {
        logic [SAMPLE_W-1:0] osc;
        logic [PHASE_W-1:0]  phase;
    } t_osc_beat;

    logic signed [SAMPLE_W-1:0] cos_lut [COS_DEPTH];
    t_osc_beat                  osc_beats_due [$];
    int                         fail_count = 0;

    // loop state and register copies
    logic [PHASE_W-1:0] phase_acc;
    longint             level_acc;
    longint             last_osc;
    longint             cfg_step;
    longint             cfg_gain;
    logic [COEFF_W-1:0] cfg_coeff;
    logic               cfg_mode;

    assign o_fails = fail_count;

    // quarter-wave taylor series in q30, folded out to a full cycle
    function automatic void fill_cos_lut();
        int     cos_div [6] = '{132, 90, 56, 30, 12, 2};
        int     sin_div [6] = '{156, 110, 72, 42, 20, 6};
        longint lim, turn, quad, rem, x, x2, c, s, v;
        lim = (longint'(1) << (SAMPLE_W - 1)) - 1;
        for (int i = 0; i < COS_DEPTH; i++) begin
            turn = (longint'(i) << 30) / COS_DEPTH;
            quad = (turn >>> 28) & 3;
            rem  = turn & ((longint'(1) << 28) - 1);
            x    = (rem * QTR_TURN_Q30) >>> 28;
            x2   = (x * x) >>> 30;
            c    = Q30_UNIT;
            s    = Q30_UNIT;
            for (int n = 0; n < 6; n++) begin
                c = Q30_UNIT - ((x2 * c) / Q30_UNIT) / cos_div[n];
                s = Q30_UNIT - ((x2 * s) / Q30_UNIT) / sin_div[n];
            end
            s = (x * s) / Q30_UNIT;
            case (quad)
                0: v = c;
                1: v = -s;
                2: v = -c;
                default: v = s;
            endcase
            v = (v * (longint'(1) << (SAMPLE_W - 1)) + (longint'(1) << 29)) >>> 30;
            if (v > lim) begin
                v = lim;
            end
            if (v < -lim) begin
                v = -lim;
            end
            cos_lut[i] = SAMPLE_W'(v);
        end
    endfunction

    function automatic void set_register(input logic [CFG_IDX_W-1:0]  idx,
                                         input logic [CFG_DATA_W-1:0] data);
        longint k;
        case (idx)
            CFG_PHASE_STEP: begin
                cfg_step = longint'($signed(data[STEP_W-1:0]));
            end
            CFG_LOOP_GAIN: begin
                k = longint'($signed(data[GAIN_W-1:0]));
                cfg_gain = (k > longint'(GAIN_MAX)) ? longint'(GAIN_MAX) : k;
            end
            CFG_FILTER_COEFF: begin
                cfg_coeff = data[COEFF_W-1:0];
            end
            CFG_DETECTOR_MODE: begin
                cfg_mode = data[0];
            end
            default: begin
            end
        endcase
    endfunction

    // one reference sample through detector, lowpass, nco and cosine lookup
    function automatic t_osc_beat advance_loop(input logic [SAMPLE_W-1:0] ref_raw);
        longint    ref_v, det, m, hi, lo, inc;
        t_osc_beat beat;
        ref_v = longint'($signed(ref_raw));
        if (cfg_mode == DET_MULT) begin
            det = (ref_v * last_osc) >>> DET_SHIFT;
            if (det > LEVEL_TOP) begin
                det = LEVEL_TOP;
            end
            if (det < LEVEL_BOTTOM) begin
                det = LEVEL_BOTTOM;
            end
        end else begin
            // zero counts as negative on both sides
            det = ((ref_v > 0) != (last_osc > 0)) ? LEVEL_TOP : LEVEL_BOTTOM;
        end
        level_acc = level_acc + ((longint'(cfg_coeff) * (det - level_acc)) >>> 16);
        m   = (longint'(1) << 31) + level_acc * cfg_gain;
        hi  = m >>> 31;
        lo  = m - hi * (longint'(1) << 31);
        inc = cfg_step * hi + ((cfg_step * lo) >>> 31);
        if (inc > HALF_TURN) begin
            inc = HALF_TURN;
        end
        if (inc < -HALF_TURN) begin
            inc = -HALF_TURN;
        end
        phase_acc  = phase_acc + PHASE_W'(inc);
        beat.osc   = cos_lut[phase_acc[PHASE_W-1 -: COS_IDX_W]];
        beat.phase = phase_acc;
        last_osc   = longint'(cos_lut[phase_acc[PHASE_W-1 -: COS_IDX_W]]);
        return beat;
    endfunction

    initial begin
        fill_cos_lut();
    end

    always @(posedge i_clk) begin
        t_osc_beat want;
        if (!i_rst_n) begin
            phase_acc = '0;
            level_acc = 0;
            last_osc  = 0;
            cfg_step  = longint'($signed(STEP_RST));
            cfg_gain  = longint'($signed(GAIN_RST));
            cfg_coeff = COEFF_RST;
            cfg_mode  = MODE_RST;
            osc_beats_due.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (osc_beats_due.size() == 0) begin
                    $error("result beat with none due: osc_sample %0d phase_word %0d",
                           $signed(i_osc_sample), i_phase_word);
                    fail_count++;
                end else begin
                    want = osc_beats_due.pop_front();
                    if (i_osc_sample !== want.osc) begin
                        $error("osc_sample mismatch: expected %0d, actual %0d",
                               $signed(want.osc), $signed(i_osc_sample));
                        fail_count++;
                    end
                    if (i_phase_word !== want.phase) begin
                        $error("phase_word mismatch: expected %0d, actual %0d",
                               want.phase, i_phase_word);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                set_register(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && i_in_ready) begin
                osc_beats_due.push_back(advance_loop(i_ref_sample));
            end
            o_pending <= osc_beats_due.size();
        end
    end

endmodule

[verif/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import apll_pkg::*;

    localparam int RAND_PHASES = 12;
    localparam int PHASE_ITEMS = 140;
    localparam int LONG_HOLD   = 400;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic [SAMPLE_W-1:0]   ref_sample = '0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [SAMPLE_W-1:0]   osc_sample;
    logic [PHASE_W-1:0]    phase_word;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    int                    fails;
    int                    pending;

    bit                    throttle   = 1'b1;
    bit                    hold_req   = 1'b0;
    int                    sent_count = 0;
    logic [PHASE_W-1:0]    trk_phase  = '0;
    logic [PHASE_W-1:0]    trk_step   = '0;
    int                    trk_amp    = 256;
    int                    trk_noise  = 0;

    always #4 clk = ~clk;

    audio_phase_locked_loop i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_ref_sample (ref_sample),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_osc_sample (osc_sample),
        .o_phase_word (phase_word),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    apll_loop_checker u_loop_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_ref_sample (ref_sample),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_osc_sample (osc_sample),
        .i_phase_word (phase_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fails      (fails),
        .o_pending    (pending)
    );

    task automatic send_ref(input logic [SAMPLE_W-1:0] v);
        if (throttle && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        ref_sample <= v;
        do @(posedge clk); while (!in_ready);
        sent_count++;
    endtask

    // stop offering and wait until every result beat has gone
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic apply_setting(input logic [STEP_W-1:0]  step,
                                 input logic [GAIN_W-1:0]  gain,
                                 input logic [COEFF_W-1:0] coeff,
                                 input logic               mode);
        drain();
        write_reg(CFG_PHASE_STEP, step);
        write_reg(CFG_LOOP_GAIN, {(CFG_DATA_W - GAIN_W)'($urandom), gain});
        write_reg(CFG_FILTER_COEFF, {(CFG_DATA_W - COEFF_W)'($urandom), coeff});
        write_reg(CFG_DETECTOR_MODE, {(CFG_DATA_W - 1)'($urandom), mode});
        // unmapped index, must leave every register alone
        write_reg(CFG_IDX_W'($urandom_range(CFG_DETECTOR_MODE + 1, 255)),
                  CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic random_setting();
        logic [STEP_W-1:0]  step;
        logic [GAIN_W-1:0]  gain;
        logic [COEFF_W-1:0] coeff;
        case ($urandom_range(0, 3))
            0: step = STEP_W'($urandom);
            1: step = STEP_W'($urandom_range(1000, 1 << 20));
            2: step = -STEP_W'($urandom_range(1000, 1 << 20));
            default: step = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
        endcase
        case ($urandom_range(0, 3))
            0: gain = GAIN_W'($urandom);
            1: gain = GAIN_W'(int'($urandom_range(0, 8192)) - 4096);
            2: gain = $urandom_range(0, 1) ? GAIN_W'(2560000) : GAIN_W'(-2560000);
            default: gain = $urandom_range(0, 1) ? 23'h3FFFFF : 23'h400000;
        endcase
        case ($urandom_range(0, 2))
            0: coeff = COEFF_W'($urandom);
            1: coeff = COEFF_W'($urandom_range(0, 2000));
            default: coeff = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
        apply_setting(step, gain, coeff, 1'($urandom));
        // reference runs close to the centre frequency so the loop can pull in
        trk_step  = step + PHASE_W'($urandom_range(0, 2047)) - PHASE_W'(1024);
        trk_amp   = $urandom_range(16, 256);
        trk_noise = $urandom_range(0, 2000);
    endtask

    // mostly a noisy triangle tone near the nco rate, the rest raw noise and extremes
    function automatic logic [SAMPLE_W-1:0] next_ref();
        int p, ramp, v;
        case ($urandom_range(0, 9))
            0: return SAMPLE_W'($urandom);
            1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            2: return SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
            default: begin
                trk_phase = trk_phase + trk_step;
                p    = int'(trk_phase[PHASE_W-1 -: 16]);
                ramp = (p >= 32768) ? 65535 - p : p;
                v    = ((2 * ramp - 32767) * trk_amp) / 256
                       + int'($urandom_range(0, 2 * trk_noise)) - trk_noise;
                if (v > 32767) begin
                    v = 32767;
                end
                if (v < -32768) begin
                    v = -32768;
                end
                return SAMPLE_W'(v);
            end
        endcase
    endfunction

    task automatic run_sink();
        forever begin
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end else if (throttle && $urandom_range(0, 2) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    endtask

    initial begin : stimulus
        rst_n <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        fork
            run_sink();
        join_none

        // register defaults, sample extremes
        send_ref(16'h0000);
        send_ref(16'h7FFF);
        send_ref(16'h8000);
        send_ref(16'h0001);
        send_ref(16'hFFFF);
        send_ref(16'h5555);
        send_ref(16'hAAAA);

        // gain is still zero, so one step lands the phase exactly on the half cycle
        apply_setting(STEP_W'(24'h800000 - sent_count * STEP_RST), '0, 16'hFFFF, DET_MULT);
        send_ref(16'h8000);
        // most negative step flips between cosine peaks, full-scale products
        apply_setting(24'h800000, '0, 16'hFFFF, DET_MULT);
        send_ref(16'h8000);
        send_ref(16'h8000);
        send_ref(16'h7FFF);
        send_ref(16'h8000);

        // gain written above its range, increment driven into the half-cycle clamp
        apply_setting(24'h7FFFFF, 23'h3FFFFF, 16'hFFFF, DET_XOR);
        send_ref(16'h7FFF);
        send_ref(16'h8000);
        send_ref(16'h0000);
        send_ref(16'h0001);
        send_ref(16'hFFFF);
        send_ref(16'h0000);

        // most negative gain, frozen lowpass
        apply_setting(24'd1, 23'h400000, 16'h0000, DET_XOR);
        send_ref(16'h7FFF);
        send_ref(16'h8000);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            random_setting();
            throttle = (ph < RAND_PHASES - 2);
            if (ph == 3) begin
                hold_req = 1'b1;
            end
            repeat (PHASE_ITEMS) send_ref(next_ref());
        end

        drain();
        repeat (20) @(posedge clk);
        if (fails == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #8ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
